// ----- design/pseudo_random_interleave_map_unit_macros.svh -----
// assertion macros for the interleave map unit checker
// expects signals clk and rst_n in the scope of use
`ifndef PSEUDO_RANDOM_INTERLEAVE_MAP_UNIT_MACROS_SVH
`define PSEUDO_RANDOM_INTERLEAVE_MAP_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PRIMAP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PRIMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/primap_pkg.sv -----
// shared constants and types of the interleave map unit
// no dependencies
package primap_pkg;

  localparam int ENTRY_W          = 12;
  localparam int INDEX_W          = 12;
  localparam int SIZE_W           = 13;
  localparam int MULT_W           = 10;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_IDX_W        = 1;
  localparam int DEFAULT_MAX_SIZE = 4096;
  localparam int MIN_SIZE         = 4;

  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(4);
  localparam logic [MULT_W-1:0] RESET_MULT = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE = 1'b0,
    REG_MULTIPLIER = 1'b1
  } cfg_reg_t;

  // table write port from the builder, address travels separately
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] data;
  } entry_wr_t;

endpackage

// ----- design/primap_if.sv -----
// valid/ready channel interfaces for queries and results
// depends on primap_pkg
interface primap_in_if;
  logic                             valid;
  logic                             ready;
  logic [primap_pkg::INDEX_W-1:0]   index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

interface primap_out_if;
  logic                             valid;
  logic                             ready;
  logic [primap_pkg::ENTRY_W-1:0]   mapped_index;
  logic                             index_error;

  modport source (output valid, output mapped_index, output index_error, input ready);
  modport sink   (input valid, input mapped_index, input index_error, output ready);
endinterface

// ----- design/primap_table_builder.sv -----
// sequencer that generates the permutation and writes it into the table
// depends on primap_pkg
module primap_table_builder #(
  parameter int MAX_SIZE = primap_pkg::DEFAULT_MAX_SIZE,
  localparam int ADDR_W  = $clog2(MAX_SIZE),
  localparam int N_W     = ADDR_W + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [N_W-1:0]                size_n,
  input  logic [primap_pkg::MULT_W-1:0] mult,
  output primap_pkg::entry_wr_t         wr,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic                          table_ready
);

  localparam int PROD_W = ADDR_W + primap_pkg::MULT_W;

  typedef enum logic [3:0] {
    ST_SETUP = 4'b0001,
    ST_IDENT = 4'b0010,
    ST_GEN   = 4'b0100,
    ST_DONE  = 4'b1000
  } build_state_t;

  build_state_t      state_r, state_nxt;
  logic [N_W-1:0]    s_r, s_nxt;
  logic [N_W-1:0]    tries_r, tries_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;

  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] mask, q, cand;
  logic              cand_ok, give_up, last;

  // one generator step p -> (t0*p + q) mod s
  assign mask    = ADDR_W'(s_r - 1'b1);
  assign q       = ADDR_W'((s_r >> 2) - 1'b1);
  assign prod    = PROD_W'(mult) * PROD_W'(p_r);
  assign cand    = (prod[ADDR_W-1:0] + q) & mask;
  assign cand_ok = {1'b0, cand} < size_n;
  assign give_up = (tries_r == s_r);
  assign last    = ({1'b0, i_r} == size_n - 1'b1);

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    tries_nxt = tries_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    wr.en     = 1'b0;
    wr.data   = '0;
    wr_addr   = i_r;
    unique case (state_r)
      ST_SETUP: begin
        if (s_r < size_n) begin
          s_nxt = s_r << 1;
        end else if (mult == '0) begin
          i_nxt     = '0;
          state_nxt = ST_IDENT;
        end else begin
          // entry 0 is always 0
          wr.en     = 1'b1;
          wr_addr   = '0;
          i_nxt     = ADDR_W'(1);
          p_nxt     = '0;
          tries_nxt = '0;
          state_nxt = ST_GEN;
        end
      end
      ST_IDENT: begin
        wr.en   = 1'b1;
        wr.data = primap_pkg::ENTRY_W'(i_r);
        if (last) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_GEN: begin
        if (cand_ok || give_up) begin
          // write the in-range candidate; search exhausted: entry falls back to 0 and iteration restarts from 0
          wr.en     = 1'b1;
          wr.data   = cand_ok ? primap_pkg::ENTRY_W'(cand) : '0;
          p_nxt     = cand_ok ? cand : '0;
          tries_nxt = '0;
          if (last) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          p_nxt     = cand;
          tries_nxt = tries_r + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
        state_nxt = ST_SETUP;
        s_nxt     = N_W'(1);
      end
    endcase
    if (restart) begin
      wr.en     = 1'b0;
      state_nxt = ST_SETUP;
      s_nxt     = N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SETUP;
      s_r     <= N_W'(1);
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tries_r <= tries_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
  end

  assign table_ready = (state_r == ST_DONE);

endmodule

// ----- design/primap_lookup.sv -----
// permutation table memory and the registered query/result stage
// depends on primap_pkg and primap_if
module primap_lookup #(
  parameter int MAX_SIZE = primap_pkg::DEFAULT_MAX_SIZE,
  localparam int ADDR_W  = $clog2(MAX_SIZE),
  localparam int N_W     = ADDR_W + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  table_ready,
  input  primap_pkg::entry_wr_t wr,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [N_W-1:0]        size_n,
  primap_in_if.sink             in_chan,
  primap_out_if.source          out_chan
);

  logic [primap_pkg::ENTRY_W-1:0] perm_mem [MAX_SIZE];
  logic [primap_pkg::ENTRY_W-1:0] rdata_r;
  logic                           err_r;
  logic                           out_valid_r;
  logic                           accept;
  logic                           in_range;

  assign in_chan.ready = table_ready && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign in_range      = 32'(in_chan.index) < 32'(size_n);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      perm_mem[wr_addr] <= wr.data;
    end
  end

  // read only on an accepted transaction so a stalled result holds
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= perm_mem[ADDR_W'(in_chan.index)];
      err_r   <= !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.mapped_index = err_r ? '0 : rdata_r;
  assign out_chan.index_error  = err_r;

endmodule

// ----- design/pseudo_random_interleave_map_unit.sv -----
// Pseudo-random interleaver map: after reset and after every configuration
// write the unit rebuilds its permutation table in a single-port memory, then
// answers index queries at one transaction per cycle while no stalled result
// blocks it, each result valid in the cycle after its query is accepted
// (one registered memory read). While the table is rebuilt in_chan.ready stays
// low. Rebuild: setup steps double s from 1 until it is at least n (the last
// of them writes entry 0 when the generator is used), then the identity map
// is written (multiplier 0), or the generator runs, one generator step per
// cycle; with a multiplier of the form 4k+1 and s of at least 8 the generator has full period.
// Here n is table_size clamped to 4..MAX_SIZE and s the next power of two.
// The table needs no clearing pass; queries are held off until it is full.
// Depends on primap_pkg, primap_if, primap_table_builder, primap_lookup.
module pseudo_random_interleave_map_unit #(
  parameter int MAX_SIZE = primap_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  primap_in_if.sink                         in_chan,
  primap_out_if.source                      out_chan,
  input  logic                              cfg_we,
  input  logic [primap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [primap_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_SIZE);
  localparam int N_W    = ADDR_W + 1;

  // configuration registers
  logic [primap_pkg::SIZE_W-1:0] table_size_r, table_size_nxt;
  logic [primap_pkg::MULT_W-1:0] multiplier_r, multiplier_nxt;

  // effective size after clamping
  logic [N_W-1:0] size_n;

  // builder to memory
  primap_pkg::entry_wr_t wr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  table_ready;

  always_comb begin
    table_size_nxt = table_size_r;
    multiplier_nxt = multiplier_r;
    if (cfg_we) begin
      unique case (primap_pkg::cfg_reg_t'(cfg_index))
        primap_pkg::REG_TABLE_SIZE: table_size_nxt = cfg_wdata[primap_pkg::SIZE_W-1:0];
        primap_pkg::REG_MULTIPLIER: multiplier_nxt = cfg_wdata[primap_pkg::MULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= primap_pkg::RESET_SIZE;
      multiplier_r <= primap_pkg::RESET_MULT;
    end else begin
      table_size_r <= table_size_nxt;
      multiplier_r <= multiplier_nxt;
    end
  end

  // sizes below the minimum run as 4, above the memory depth as MAX_SIZE
  always_comb begin
    if (32'(table_size_r) < primap_pkg::MIN_SIZE) begin
      size_n = N_W'(primap_pkg::MIN_SIZE);
    end else if (32'(table_size_r) > MAX_SIZE) begin
      size_n = N_W'(MAX_SIZE);
    end else begin
      size_n = N_W'(table_size_r);
    end
  end

  // any write invalidates the table and restarts the build
  primap_table_builder #(
    .MAX_SIZE (MAX_SIZE)
  ) u_builder (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_we),
    .size_n      (size_n),
    .mult        (multiplier_r),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .table_ready (table_ready)
  );

  // queries are interlocked against the build through table_ready
  primap_lookup #(
    .MAX_SIZE (MAX_SIZE)
  ) u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .table_ready (table_ready),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .size_n      (size_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

endmodule

// ----- design/primap_checker.sv -----
// port-level assertions for the interleave map unit, bound to the top level
// depends on primap_pkg and the macros header
`include "pseudo_random_interleave_map_unit_macros.svh"

module primap_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [primap_pkg::ENTRY_W-1:0] out_mapped_index,
  input logic                           out_index_error
);

  `PRIMAP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mapped_index) && $stable(out_index_error), "stalled result changed")
  `PRIMAP_ASSERT_IMPL(a_err_zero, out_valid && out_index_error, out_mapped_index == '0, "error result with nonzero index")
  `PRIMAP_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid, "accepted transaction gave no result")
  `PRIMAP_ASSERT_IMPL(a_no_overrun, in_ready && out_valid, out_ready, "query taken over a stalled result")
  `PRIMAP_ASSERT_NEXT(a_cfg_rebuild, cfg_we, !in_ready, "query taken right after a config write")

endmodule

bind pseudo_random_interleave_map_unit primap_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_mapped_index (out_chan.mapped_index),
  .out_index_error  (out_chan.index_error)
);

// ----- verif/primap_checker.sv -----
// scoreboard for the interleave map unit: tracks register writes, predicts each
// query's mapped index and error flag, and compares against the result channel
// depends on primap_pkg and primap_if
`timescale 1ns / 1ps

module interleave_map_checker #(
  parameter int MAX_SIZE = primap_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  primap_in_if                              in_mon,
  primap_out_if                             out_mon,
  input  logic                              cfg_we,
  input  logic [primap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [primap_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                pending_cnt,
  output int                                fail_cnt
);

  typedef struct packed {
    logic [primap_pkg::ENTRY_W-1:0] mapped;
    logic                           err;
  } map_result_t;

  logic [primap_pkg::ENTRY_W-1:0] perm_copy [MAX_SIZE];
  logic [primap_pkg::SIZE_W-1:0]  size_reg;
  logic [primap_pkg::MULT_W-1:0]  mult_reg;
  bit                             perm_stale;
  map_result_t                    expected_maps [$];
  int                             fails = 0;

  function automatic int unsigned clamp_size(logic [primap_pkg::SIZE_W-1:0] raw);
    if (raw < primap_pkg::MIN_SIZE) return primap_pkg::MIN_SIZE;
    if (raw > MAX_SIZE) return MAX_SIZE;
    return raw;
  endfunction

  // identity for multiplier zero, else the skipping generator walk
  task automatic rebuild_perm();
    int unsigned n, s, q, p, t0, tries, i;
    n  = clamp_size(size_reg);
    t0 = mult_reg;
    if (t0 == 0) begin
      for (i = 0; i < n; i++) perm_copy[i] = primap_pkg::ENTRY_W'(i);
    end else begin
      s = 1;
      while (s < n) s = s << 1;
      q = s / 4 - 1;
      perm_copy[0] = '0;
      p = 0;
      for (i = 1; i < n; i++) begin
        p = (t0 * p + q) & (s - 1);
        tries = 0;
        while (p >= n && tries < s) begin
          p = (t0 * p + q) & (s - 1);
          tries++;
        end
        if (p >= n) p = 0;
        perm_copy[i] = primap_pkg::ENTRY_W'(p);
      end
    end
    perm_stale = 1'b0;
  endtask

  function automatic map_result_t map_query(logic [primap_pkg::INDEX_W-1:0] idx);
    map_result_t r;
    if (idx >= clamp_size(size_reg)) begin
      r.mapped = '0;
      r.err    = 1'b1;
    end else begin
      r.mapped = perm_copy[idx];
      r.err    = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      size_reg   = primap_pkg::RESET_SIZE;
      mult_reg   = primap_pkg::RESET_MULT;
      perm_stale = 1'b1;
      expected_maps.delete();
    end else begin
      if (cfg_we) begin
        case (primap_pkg::cfg_reg_t'(cfg_index))
          primap_pkg::REG_TABLE_SIZE: size_reg = cfg_wdata[primap_pkg::SIZE_W-1:0];
          primap_pkg::REG_MULTIPLIER: mult_reg = cfg_wdata[primap_pkg::MULT_W-1:0];
          default: ;
        endcase
        perm_stale = 1'b1;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (perm_stale) rebuild_perm();
        expected_maps.push_back(map_query(in_mon.index));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_maps.size() == 0) begin
          fails++;
          $display("%0t: result expected none actual mapped_index %0d index_error %0b",
                   $time, out_mon.mapped_index, out_mon.index_error);
        end else begin
          want = expected_maps.pop_front();
          if (out_mon.mapped_index !== want.mapped) begin
            fails++;
            $display("%0t: mapped_index expected %0d actual %0d",
                     $time, want.mapped, out_mon.mapped_index);
          end
          if (out_mon.index_error !== want.err) begin
            fails++;
            $display("%0t: index_error expected %0b actual %0b",
                     $time, want.err, out_mon.index_error);
          end
        end
      end
    end
    pending_cnt <= expected_maps.size();
    fail_cnt    <= fails;
  end

endmodule

// ----- verif/testbench.sv -----
// top of the interleave map unit testbench: clock, reset, stimulus and verdict
// depends on primap_pkg, primap_if, the unit and interleave_map_checker
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF       = 4;
  localparam int RANDOM_QUERIES = 1730;
  localparam int LONG_HOLD      = 400;
  localparam int QUIET_LIMIT    = 100000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_PHASE     = 2;

  bit                                clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [primap_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [primap_pkg::CFG_DATA_W-1:0] cfg_wdata;

  primap_in_if  in_chan ();
  primap_out_if out_chan ();

  int pending_cnt;
  int fail_cnt;
  int hold_requests = 0;
  int burst_left = 0;

  // last multiplier written, used to order the two writes of a new setting
  logic [primap_pkg::MULT_W-1:0] cur_mult;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  pseudo_random_interleave_map_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  interleave_map_checker map_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pending_cnt (pending_cnt),
    .fail_cnt    (fail_cnt)
  );

  // a multiplier not of the form 4k+1 may search up to the give-up limit for each entry,
  // so it is only paired with small sizes
  function automatic bit slow_mult(logic [primap_pkg::MULT_W-1:0] m);
    return m != '0 && m[1:0] != 2'b01;
  endfunction

  // one query transaction; bursts of random length separated by random gaps
  task automatic send_query(input logic [primap_pkg::INDEX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        2, 3, 4: gap = $urandom_range(1, 6);
        default: gap = $urandom_range(7, 30);
      endcase
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.index <= idx;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // drain every outstanding result, let the read pipe settle, then write both
  // registers back to back; the intermediate setting is kept cheap to build
  task automatic load_config(input logic [primap_pkg::SIZE_W-1:0] size,
                             input logic [primap_pkg::MULT_W-1:0] mult);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    if (slow_mult(cur_mult)) begin
      cfg_index <= primap_pkg::REG_MULTIPLIER;
      cfg_wdata <= primap_pkg::CFG_DATA_W'(mult);
      @(posedge clk);
      cfg_index <= primap_pkg::REG_TABLE_SIZE;
      cfg_wdata <= primap_pkg::CFG_DATA_W'(size);
    end else begin
      cfg_index <= primap_pkg::REG_TABLE_SIZE;
      cfg_wdata <= primap_pkg::CFG_DATA_W'(size);
      @(posedge clk);
      cfg_index <= primap_pkg::REG_MULTIPLIER;
      cfg_wdata <= primap_pkg::CFG_DATA_W'(mult);
    end
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mult = mult;
  endtask

  // result side: changing stall patterns, plus a long hold-off on request
  initial begin
    int mode;
    int span;
    int served;
    mode   = 0;
    span   = 0;
    served = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        // long hold-off so the unit fills and stalls its input
        served = hold_requests;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 300);
        end
        span--;
        case (mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= 1'($urandom_range(0, 1));
          2:       out_chan.ready <= ($urandom_range(0, 4) == 0);
          default: out_chan.ready <= (span % 3 == 0);
        endcase
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int                             sent;
    int                             phase;
    int                             count;
    int                             n;
    logic [primap_pkg::SIZE_W-1:0]  size;
    logic [primap_pkg::MULT_W-1:0]  mult;
    logic [primap_pkg::INDEX_W-1:0] idx;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= primap_pkg::REG_TABLE_SIZE;
    cfg_wdata     <= '0;
    in_chan.valid <= 1'b0;
    in_chan.index <= '0;
    cur_mult = primap_pkg::RESET_MULT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: size four identity, both bounds and out of range
    send_query(12'd0);
    send_query(12'd3);
    send_query(12'd4);
    send_query(12'd4095);

    // size above maximum clamps to 4096, every size bit set
    load_config(13'd8191, 10'd1021);
    send_query(12'd0);
    send_query(12'd4095);
    send_query(12'd2048);
    send_query(12'd1);

    // size below minimum clamps to four; nonzero multiplier gives all zeros
    load_config(13'd0, 10'd5);
    send_query(12'd0);
    send_query(12'd1);
    send_query(12'd2);
    send_query(12'd3);
    send_query(12'd4);

    // multiplier not of the form 4k+1, search may give up and fall back to 0
    load_config(13'd37, 10'd1022);
    send_query(12'd0);
    send_query(12'd36);
    send_query(12'd37);
    send_query(12'd20);

    // exact maximum size with the smallest generator multiplier
    load_config(13'd4096, 10'd1);
    send_query(12'd4095);
    send_query(12'd0);
    send_query(12'd1000);

    // random settings, mostly small tables, each followed by a run of queries
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_QUERIES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: size = primap_pkg::SIZE_W'($urandom_range(4, 64));
        5, 6:          size = primap_pkg::SIZE_W'($urandom_range(65, 1024));
        7:             size = primap_pkg::SIZE_W'($urandom_range(1025, 4096));
        8:             size = primap_pkg::SIZE_W'($urandom_range(0, 3));
        default:       size = primap_pkg::SIZE_W'($urandom_range(4097, 8191));
      endcase
      if (phase == HOLD_PHASE) size = primap_pkg::SIZE_W'($urandom_range(16, 64));
      n = (size < primap_pkg::MIN_SIZE) ? primap_pkg::MIN_SIZE :
          (size > primap_pkg::DEFAULT_MAX_SIZE) ? primap_pkg::DEFAULT_MAX_SIZE : size;
      case ($urandom_range(0, 9))
        0, 1:    mult = '0;
        8, 9:    mult = (n <= 100) ? primap_pkg::MULT_W'($urandom_range(0, 1023))
                                   : primap_pkg::MULT_W'(4 * $urandom_range(0, 255) + 1);
        default: mult = primap_pkg::MULT_W'(4 * $urandom_range(0, 255) + 1);
      endcase
      load_config(size, mult);
      if (phase == HOLD_PHASE) hold_requests <= hold_requests + 1;
      count = $urandom_range(40, 100);
      repeat (count) begin
        case ($urandom_range(0, 19))
          16:      idx = primap_pkg::INDEX_W'(n - 1);
          17:      idx = primap_pkg::INDEX_W'(n);
          18, 19:  idx = primap_pkg::INDEX_W'($urandom_range(0, 4095));
          default: idx = primap_pkg::INDEX_W'($urandom_range(0, n - 1));
        endcase
        send_query(idx);
      end
      sent += count;
      phase++;
    end

    // drain, then allow for the read latency before the verdict
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
